/* hdl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Request and response structs, the command format of the internal queue,
// frame kinds and the byte codes the parser looks for.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // Payload buffer geometry
  localparam int unsigned BUF_DEPTH = 64;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W     = 7;   // width of stored_count
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

  // Byte codes
  localparam logic [7:0] BYTE_OPEN_BIN  = 8'hFF;
  localparam logic [7:0] BYTE_CLOSE_BIN = 8'hFE;
  localparam logic [7:0] BYTE_OPEN_TEXT = 8'h3E;  // '>'
  localparam logic [7:0] BYTE_CR        = 8'h0D;
  localparam logic [7:0] BYTE_BS        = 8'h08;
  localparam logic [7:0] BYTE_NUL       = 8'h00;

  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_BINARY = 2'd2,
    KIND_TEXT   = 2'd3
  } kind_e;

  // Classified operation, decided by the front end
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_READ,
    OP_RX_OPEN_BIN,
    OP_RX_CLOSE_BIN,
    OP_RX_OPEN_TEXT,
    OP_RX_CR,
    OP_RX_BS,
    OP_RX_PLAIN
  } op_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [5:0] read_index;
  } sfr_req_t;

  typedef struct packed {
    logic [1:0]       frame_kind;
    logic             frame_done;
    logic [CNT_W-1:0] stored_count;
    logic [7:0]       last_byte;
    logic [7:0]       read_data;
    logic             overflow;
  } sfr_rsp_t;

  // Queue entry between front and back
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [5:0] index;
    logic       in_range;  // read index lies inside the buffer
  } sfr_cmd_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic valid;
  } sfr_qstat_t;

  typedef struct packed {
    logic pop;
  } sfr_qctrl_t;

endpackage

`default_nettype wire

/* hdl/serial_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit: serial frame receiver
// Classifies received bytes into single-byte messages, binary frames and
// text frames, collects payload bytes in a buffer and answers buffer reads.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------
//  in      | in_valid_i / in_stall_o    | in_req_i  (mode, byte, index)
//  out     | out_valid_o / out_stall_i  | out_rsp_o (state after request)
//
//  Throughput is one request per cycle while out_stall_i is low; a request's
//  response is presented once it has passed the queue write and then the
//  parser execute registers.
//  The parser step plus one buffer access per cycle sets that rate.
//  Reset clears parser state and queue; buffer contents stay undefined
//  until written, no clearing pass is needed.
//  A stalled response holds the parser; the two-entry queue keeps taking
//  requests until it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_unit
  import sfr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire sfr_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sfr_rsp_t      out_rsp_o
);

  sfr_cmd_t   cmd;
  sfr_qstat_t qstat;
  sfr_qctrl_t qctrl;

  // Front: decode and queue requests
  sfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .cmd_o      (cmd),
    .qstat_o    (qstat),
    .qctrl_i    (qctrl)
  );

  // Back: run the parser and the buffer, drive responses
  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .qstat_i     (qstat),
    .qctrl_o     (qctrl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Never pop an empty queue
  a_pop_needs_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qctrl.pop |-> qstat.valid)
    else $error("queue popped while empty");

  // Count never exceeds buffer depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.stored_count <= DEPTH_CNT))
    else $error("stored_count above buffer depth");

  // A finished message always has a kind
  a_done_has_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.frame_done |-> (out_rsp_o.frame_kind != KIND_NONE))
    else $error("frame_done without frame kind");

  // A single-byte message stores no payload
  a_single_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.frame_kind == KIND_SINGLE)
      |-> (out_rsp_o.stored_count == '0))
    else $error("single-byte message with stored payload");

endmodule

`default_nettype wire

/* hdl/sfr_ram.sv */
// ----------------------------------------------------------------------------
// sfr_ram: generic single-port RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/sfr_front.sv */
// ----------------------------------------------------------------------------
// sfr_front: request intake and classification
// Decode each request into an operation and push it into a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front
  import sfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire sfr_req_t   in_req_i,
  output sfr_cmd_t        cmd_o,
  output sfr_qstat_t      qstat_o,
  input  wire sfr_qctrl_t qctrl_i
);

  localparam int unsigned QDEPTH = 2;

  sfr_cmd_t   cmd_in;
  sfr_cmd_t   mem_q [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // Classify the request
  always_comb begin
    cmd_in.data     = in_req_i.data_byte;
    cmd_in.index    = in_req_i.read_index;
    cmd_in.in_range = ({1'b0, in_req_i.read_index} < DEPTH_CNT);
    cmd_in.op       = OP_NOP;
    unique case (mode_e'(in_req_i.mode))
      MODE_RX: begin
        unique case (in_req_i.data_byte)
          BYTE_OPEN_BIN:  cmd_in.op = OP_RX_OPEN_BIN;
          BYTE_CLOSE_BIN: cmd_in.op = OP_RX_CLOSE_BIN;
          BYTE_OPEN_TEXT: cmd_in.op = OP_RX_OPEN_TEXT;
          BYTE_CR:        cmd_in.op = OP_RX_CR;
          BYTE_BS:        cmd_in.op = OP_RX_BS;
          default:        cmd_in.op = OP_RX_PLAIN;
        endcase
      end
      MODE_CLEAR: cmd_in.op = OP_CLEAR;
      MODE_READ:  cmd_in.op = OP_READ;
      MODE_NONE:  cmd_in.op = OP_NOP;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = qctrl_i.pop && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_o         = mem_q[rd_ptr_q];
  assign qstat_o.valid = (cnt_q != 2'd0);

endmodule

`default_nettype wire

/* hdl/sfr_back.sv */
// ----------------------------------------------------------------------------
// sfr_back: frame parser and payload buffer
// Execute one queued operation per cycle unless a stalled response holds it,
// update the parser state, access the buffer and present the response.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back
  import sfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire sfr_cmd_t   cmd_i,
  input  wire sfr_qstat_t qstat_i,
  output sfr_qctrl_t      qctrl_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output sfr_rsp_t        out_rsp_o
);

  kind_e            kind_q, kind_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             done_q, done_d;
  logic             ovf_q, ovf_d;
  logic [7:0]       last_q, last_d;
  logic             rdsel_q, rdsel_d;
  logic             valid_q, valid_d;
  logic             adv;

  logic              ram_we, ram_re;
  logic [BUF_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              has_room;

  // Advance when the response slot is free or being taken
  assign adv          = qstat_i.valid && (!valid_q || !out_stall_i);
  assign qctrl_o.pop  = adv;
  assign has_room     = (fill_q < DEPTH_CNT);

  always_comb begin
    kind_d    = kind_q;
    fill_d    = fill_q;
    done_d    = done_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    rdsel_d   = rdsel_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = fill_q[BUF_AW-1:0];
    ram_wdata = cmd_i.data;
    if (adv) begin
      rdsel_d = 1'b0;
      case (cmd_i.op) inside
        OP_CLEAR: begin
          kind_d = KIND_NONE;
          fill_d = '0;
          done_d = 1'b0;
          ovf_d  = 1'b0;
        end
        OP_READ: begin
          ram_re   = 1'b1;
          ram_addr = cmd_i.index[BUF_AW-1:0];
          rdsel_d  = cmd_i.in_range;
        end
        OP_RX_OPEN_BIN, OP_RX_CLOSE_BIN, OP_RX_OPEN_TEXT, OP_RX_CR, OP_RX_BS,
        OP_RX_PLAIN: begin
          last_d = cmd_i.data;
          unique case (kind_q)
            KIND_NONE: begin
              if (cmd_i.op == OP_RX_OPEN_BIN) begin
                kind_d = KIND_BINARY;
              end else if (cmd_i.op == OP_RX_OPEN_TEXT) begin
                kind_d = KIND_TEXT;
              end else begin
                kind_d = KIND_SINGLE;
                done_d = 1'b1;
              end
            end
            KIND_BINARY: begin
              if (cmd_i.op == OP_RX_CLOSE_BIN) begin
                done_d = 1'b1;
              end else if (has_room) begin
                ram_we = 1'b1;
                fill_d = fill_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            KIND_TEXT: begin
              if (cmd_i.op == OP_RX_CR && fill_q != '0) begin
                // terminate: store a zero when there is room
                ram_we    = has_room;
                ram_wdata = BYTE_NUL;
                done_d    = 1'b1;
              end else if (cmd_i.op == OP_RX_BS) begin
                if (fill_q != '0) begin
                  fill_d = fill_q - 1'b1;
                end
              end else if (has_room) begin
                ram_we = 1'b1;
                fill_d = fill_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            KIND_SINGLE: begin
              // later bytes only update last_byte
            end
            default: begin
            end
          endcase
        end
        default: begin
          // no operation: report state only
        end
      endcase
    end
  end

  always_comb begin
    if (adv) begin
      valid_d = 1'b1;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_NONE;
      fill_q  <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
      last_q  <= 8'h00;
      rdsel_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      kind_q  <= kind_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      rdsel_q <= rdsel_d;
      valid_q <= valid_d;
    end
  end

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // State registers hold still until the response is taken
  always_comb begin
    out_rsp_o.frame_kind   = kind_q;
    out_rsp_o.frame_done   = done_q;
    out_rsp_o.stored_count = fill_q;
    out_rsp_o.last_byte    = last_q;
    out_rsp_o.read_data    = rdsel_q ? ram_rdata : 8'h00;
    out_rsp_o.overflow     = ovf_q;
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire
